// File: hdl/lfsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfsc_pkg
// Shared types, codes and character constants for the filter syntax checker.
// ----------------------------------------------------------------------------
package lfsc_pkg;

	localparam int unsigned MAX_DEPTH_DEF = 16;

	typedef logic [7:0] char_t;
	typedef logic [3:0] pos_t;
	typedef logic [1:0] kind_t;

	// parse positions
	localparam pos_t POS_OPEN_TOP   = 4'd0;
	localparam pos_t POS_EXPR_START = 4'd1;
	localparam pos_t POS_KEY        = 4'd2;
	localparam pos_t POS_VAL_EQ     = 4'd3;
	localparam pos_t POS_VAL_INT    = 4'd4;
	localparam pos_t POS_NOT_OPEN   = 4'd5;
	localparam pos_t POS_LIST       = 4'd6;
	localparam pos_t POS_NOT_CLOSE  = 4'd7;
	localparam pos_t POS_DONE       = 4'd8;

	// frame kinds; the compound kinds count closed operands, saturating at two
	localparam kind_t KIND_NOT   = 2'd0;
	localparam kind_t KIND_COMP0 = 2'd1;
	localparam kind_t KIND_COMP1 = 2'd2;
	localparam kind_t KIND_COMP2 = 2'd3;

	localparam char_t CH_NUL    = 8'h00;
	localparam char_t CH_LPAR   = 8'h28;
	localparam char_t CH_RPAR   = 8'h29;
	localparam char_t CH_STAR   = 8'h2A;
	localparam char_t CH_BSLASH = 8'h5C;
	localparam char_t CH_BANG   = 8'h21;
	localparam char_t CH_AMP    = 8'h26;
	localparam char_t CH_BAR    = 8'h7C;
	localparam char_t CH_EQ     = 8'h3D;
	localparam char_t CH_LT     = 8'h3C;
	localparam char_t CH_GT     = 8'h3E;
	localparam char_t CH_MINUS  = 8'h2D;
	localparam char_t CH_ZERO   = 8'h30;
	localparam char_t CH_NINE   = 8'h39;

	function automatic logic is_special(input char_t c);
		return (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_STAR) || (c == CH_BSLASH) ||
			(c == CH_BANG) || (c == CH_AMP) || (c == CH_BAR) || (c == CH_EQ) ||
			(c == CH_LT) || (c == CH_GT);
	endfunction

	function automatic logic is_num_char(input char_t c);
		return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_MINUS);
	endfunction

endpackage
`default_nettype wire

// File: hdl/ldap_filter_syntax_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldap_filter_syntax_checker
// Byte-serial syntax check of a parenthesised search filter string.
// ----------------------------------------------------------------------------
// One byte of the filter string is taken per transaction on the item channel,
// with last marking the final byte; one byte per cycle is taken unless a last
// byte waits on an unaccepted result. Each byte is registered, then a single
// pass of parse logic updates a small state and the innermost two frame kinds
// held in registers; deeper frames live in a small stack memory whose
// next-needed entry is always prefetched, so a close paren never waits. On the
// last byte a single result transaction carries valid_res from the result
// register, and all parse state returns to its reset values for the next
// string. The only back-pressure comes from an unaccepted result: a last byte
// then waits in the input register. There is no clearing pass after reset.
module ldap_filter_syntax_checker
	import lfsc_pkg::*;
#(
	parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic [7:0] character,
	input  wire logic       last,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic            valid_res
);

	localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
	localparam int unsigned AW = $clog2(MAX_DEPTH);

	// input register
	logic    vld_s1;
	char_t   char_s1;
	logic    last_s1;
	logic    s1_go;
	logic    adv;

	// parse state
	pos_t          pos_q, pos_n;
	logic          esc_q, esc_n;
	logic          seg_q, seg_n;
	logic          allint_q, allint_n;
	logic          star_q, star_n;
	logic          err_q, err_n;
	logic [DW-1:0] depth_q, depth_n;
	kind_t         top_q, top_n;
	kind_t         below_q, below_n;
	kind_t         rd_q;
	kind_t         stk_mem [MAX_DEPTH];

	logic    push_req, pop_req, push, pop;
	logic    esc_c, seg_c, spec;
	logic    verdict;
	logic [DW-1:0] depth_m2, depth_m4;

	logic    res_valid_q;
	logic    valid_res_q;

	assign s1_go      = !last_s1 || !res_valid_q || !result_stall;
	assign adv        = vld_s1 && s1_go;
	assign item_stall = vld_s1 && !s1_go;

	assign spec     = is_special(char_s1);
	assign depth_m2 = depth_q - DW'(2);
	assign depth_m4 = depth_q - DW'(4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			char_s1 <= character;
			last_s1 <= last;
		end
	end

	always_comb begin
		pos_n    = pos_q;
		esc_n    = esc_q;
		seg_n    = seg_q;
		allint_n = allint_q;
		star_n   = star_q;
		err_n    = err_q;
		depth_n  = depth_q;
		top_n    = top_q;
		below_n  = below_q;
		push_req = 1'b0;
		pop_req  = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		esc_c    = 1'b0;
		seg_c    = 1'b0;

		if (!err_q) begin
			if (char_s1 == CH_NUL) begin
				err_n = 1'b1;
			end else begin
				unique case (pos_q)
					POS_OPEN_TOP, POS_NOT_OPEN: begin
						if (char_s1 == CH_LPAR) push_req = 1'b1;
						else err_n = 1'b1;
					end
					POS_EXPR_START, POS_KEY: begin
						if (pos_q == POS_EXPR_START &&
							(char_s1 == CH_AMP || char_s1 == CH_BAR)) begin
							top_n = KIND_COMP0;
							pos_n = POS_LIST;
						end else if (pos_q == POS_EXPR_START && char_s1 == CH_BANG) begin
							top_n = KIND_NOT;
							pos_n = POS_NOT_OPEN;
						end else begin
							// a key starts afresh on its first byte
							esc_c = (pos_q == POS_KEY) && esc_q;
							seg_c = (pos_q == POS_KEY) && seg_q;
							pos_n = POS_KEY;
							esc_n = esc_c;
							seg_n = seg_c;
							if (esc_c) begin
								if (!spec) err_n = 1'b1;
								esc_n = 1'b0;
								seg_n = 1'b1;
							end else if (char_s1 == CH_BSLASH) begin
								esc_n = 1'b1;
							end else if (!spec) begin
								seg_n = 1'b1;
							end else if (!seg_c) begin
								err_n = 1'b1;
							end else if (char_s1 == CH_EQ) begin
								pos_n  = POS_VAL_EQ;
								seg_n  = 1'b0;
								star_n = 1'b0;
							end else if (char_s1 == CH_GT || char_s1 == CH_LT) begin
								pos_n    = POS_VAL_INT;
								seg_n    = 1'b0;
								allint_n = 1'b1;
							end else begin
								err_n = 1'b1;
							end
						end
					end
					POS_VAL_EQ: begin
						if (esc_q) begin
							if (!spec) err_n = 1'b1;
							esc_n = 1'b0;
							seg_n = 1'b1;
						end else if (char_s1 == CH_BSLASH) begin
							esc_n = 1'b1;
						end else if (!spec) begin
							seg_n = 1'b1;
						end else if (char_s1 == CH_STAR) begin
							if (star_q && !seg_q) err_n = 1'b1;
							star_n = 1'b1;
							seg_n  = 1'b0;
						end else if ((!star_q && !seg_q) || char_s1 != CH_RPAR) begin
							err_n = 1'b1;
						end else begin
							pop_req = 1'b1;
						end
					end
					POS_VAL_INT: begin
						if (esc_q) begin
							if (!spec) err_n = 1'b1;
							esc_n = 1'b0;
							seg_n = 1'b1;
						end else if (char_s1 == CH_BSLASH) begin
							esc_n = 1'b1;
						end else if (!spec) begin
							seg_n = 1'b1;
							if (!is_num_char(char_s1)) allint_n = 1'b0;
						end else if (!seg_q || !allint_q || char_s1 != CH_RPAR) begin
							err_n = 1'b1;
						end else begin
							pop_req = 1'b1;
						end
					end
					POS_LIST: begin
						if (char_s1 == CH_LPAR) push_req = 1'b1;
						else if (char_s1 == CH_RPAR && top_q == KIND_COMP2) pop_req = 1'b1;
						else err_n = 1'b1;
					end
					POS_NOT_CLOSE: begin
						if (char_s1 == CH_RPAR) pop_req = 1'b1;
						else err_n = 1'b1;
					end
					default: err_n = 1'b1;
				endcase
			end
		end

		if (push_req) begin
			if (depth_q >= DW'(MAX_DEPTH)) begin
				err_n = 1'b1;
			end else begin
				push    = 1'b1;
				depth_n = depth_q + DW'(1);
				pos_n   = POS_EXPR_START;
				below_n = top_q;
			end
		end

		if (pop_req) begin
			if (depth_q == '0) begin
				err_n = 1'b1;
			end else begin
				pop     = 1'b1;
				depth_n = depth_q - DW'(1);
				if (depth_q == DW'(1)) pos_n = POS_DONE;
				else if (below_q == KIND_NOT) pos_n = POS_NOT_CLOSE;
				else pos_n = POS_LIST;
				// the parent becomes the top; a compound parent counts one more closed operand, saturating at two
				if (below_q == KIND_NOT || below_q == KIND_COMP2) top_n = below_q;
				else top_n = below_q + kind_t'(1);
				below_n = rd_q;
			end
		end

		verdict = !err_n && (pos_n == POS_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_OPEN_TOP;
			esc_q    <= 1'b0;
			seg_q    <= 1'b0;
			allint_q <= 1'b1;
			star_q   <= 1'b0;
			err_q    <= 1'b0;
			depth_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				pos_q    <= POS_OPEN_TOP;
				esc_q    <= 1'b0;
				seg_q    <= 1'b0;
				allint_q <= 1'b1;
				star_q   <= 1'b0;
				err_q    <= 1'b0;
				depth_q  <= '0;
			end else begin
				pos_q    <= pos_n;
				esc_q    <= esc_n;
				seg_q    <= seg_n;
				allint_q <= allint_n;
				star_q   <= star_n;
				err_q    <= err_n;
				depth_q  <= depth_n;
			end
		end
	end

	// frame stack: top and next-below in registers, the rest in memory;
	// rd_q always holds the entry two below the top
	always_ff @(posedge clk) begin
		if (adv) begin
			top_q   <= top_n;
			below_q <= below_n;
			if (push && depth_q >= DW'(2)) begin
				stk_mem[depth_m2[AW-1:0]] <= below_q;
			end
			if (push) begin
				rd_q <= below_q;
			end else if (pop && depth_q >= DW'(4)) begin
				rd_q <= stk_mem[depth_m4[AW-1:0]];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			valid_res_q <= verdict;
		end
	end

	assign result_valid = res_valid_q;
	assign valid_res    = valid_res_q;

	// ------------------------------------------------------------------------
	// assertions
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH))
		else $error("nesting depth beyond limit");

	a_done_closed: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == POS_DONE |-> depth_q == '0)
		else $error("top level closed with frames still open");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> pos_q == POS_OPEN_TOP && depth_q == '0 && !err_q && result_valid)
		else $error("state not cleared or no result after last byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> vld_s1 && last_s1 && res_valid_q)
		else $error("input stalled without a pending result");

endmodule
`default_nettype wire

// File: tb/lfsc_checker.sv
// ----------------------------------------------------------------------------
// lfsc_checker
// Watches both channels of the filter syntax checker, tracks the grammar of
// each accepted byte itself and compares every returned verdict in order.
// ----------------------------------------------------------------------------
module lfsc_checker
	import lfsc_pkg::*;
#(
	parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_stall,
	input  logic [7:0] character,
	input  logic       last,
	input  logic       result_valid,
	input  logic       result_stall,
	input  logic       valid_res,
	output int         fail_count,
	output int         pending,
	output int         filters_judged,
	output int         filters_valid,
	output int         bytes_taken
);

	pos_t  pos;
	logic  esc_pending;
	logic  seg_nonempty;
	logic  value_is_int;
	logic  star_seen;
	logic  bad;
	int    depth;
	kind_t frames [MAX_DEPTH];
	bit    expected_verdicts [$];
	bit    want;

	function automatic bit is_meta(input char_t c);
		case (c)
			CH_LPAR, CH_RPAR, CH_STAR, CH_BSLASH, CH_BANG,
			CH_AMP, CH_BAR, CH_EQ, CH_LT, CH_GT: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// frame contents are only ever read after being written, so left alone here
	function void restart_parse();
		pos          = POS_OPEN_TOP;
		esc_pending  = 1'b0;
		seg_nonempty = 1'b0;
		value_is_int = 1'b1;
		star_seen    = 1'b0;
		bad          = 1'b0;
		depth        = 0;
	endfunction

	function void open_level();
		if (depth >= MAX_DEPTH) begin
			bad = 1'b1;
			return;
		end
		depth++;
		pos = POS_EXPR_START;
	endfunction

	function void close_level();
		kind_t k;
		if (depth == 0 || depth > MAX_DEPTH) begin
			bad = 1'b1;
			return;
		end
		depth--;
		if (depth == 0) begin
			pos = POS_DONE;
			return;
		end
		k = frames[depth - 1];
		if (k == KIND_NOT) begin
			pos = POS_NOT_CLOSE;
		end else begin
			// operand count saturates at two
			if (k != KIND_COMP2)
				frames[depth - 1] = kind_t'(k + 1'b1);
			pos = POS_LIST;
		end
	endfunction

	// returns 1 when the byte belongs to an escape sequence
	function bit eat_escape(input char_t c);
		if (esc_pending) begin
			if (!is_meta(c))
				bad = 1'b1;
			esc_pending  = 1'b0;
			seg_nonempty = 1'b1;
			return 1'b1;
		end
		if (c == CH_BSLASH) begin
			esc_pending = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function void parse_byte(input char_t c);
		if (c == CH_NUL) begin
			bad = 1'b1;
			return;
		end
		if (pos == POS_EXPR_START) begin
			if (c == CH_AMP || c == CH_BAR) begin
				frames[depth - 1] = KIND_COMP0;
				pos = POS_LIST;
				return;
			end
			if (c == CH_BANG) begin
				frames[depth - 1] = KIND_NOT;
				pos = POS_NOT_OPEN;
				return;
			end
			// anything else starts a key and is handled as its first byte
			pos          = POS_KEY;
			seg_nonempty = 1'b0;
			esc_pending  = 1'b0;
		end
		case (pos)
			POS_OPEN_TOP, POS_NOT_OPEN: begin
				if (c == CH_LPAR)
					open_level();
				else
					bad = 1'b1;
			end
			POS_KEY: begin
				if (!eat_escape(c)) begin
					if (!is_meta(c)) begin
						seg_nonempty = 1'b1;
					end else if (!seg_nonempty) begin
						bad = 1'b1;
					end else if (c == CH_EQ) begin
						pos          = POS_VAL_EQ;
						seg_nonempty = 1'b0;
						star_seen    = 1'b0;
					end else if (c == CH_GT || c == CH_LT) begin
						pos          = POS_VAL_INT;
						seg_nonempty = 1'b0;
						value_is_int = 1'b1;
					end else begin
						bad = 1'b1;
					end
				end
			end
			POS_VAL_EQ: begin
				if (!eat_escape(c)) begin
					if (!is_meta(c)) begin
						seg_nonempty = 1'b1;
					end else if (c == CH_STAR) begin
						if (star_seen && !seg_nonempty)
							bad = 1'b1;
						star_seen    = 1'b1;
						seg_nonempty = 1'b0;
					end else if ((!star_seen && !seg_nonempty) || c != CH_RPAR) begin
						bad = 1'b1;
					end else begin
						close_level();
					end
				end
			end
			POS_VAL_INT: begin
				if (!eat_escape(c)) begin
					if (!is_meta(c)) begin
						seg_nonempty = 1'b1;
						if (!((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS))
							value_is_int = 1'b0;
					end else if (!seg_nonempty || !value_is_int || c != CH_RPAR) begin
						bad = 1'b1;
					end else begin
						close_level();
					end
				end
			end
			POS_LIST: begin
				if (c == CH_LPAR)
					open_level();
				else if (c == CH_RPAR && frames[depth - 1] == KIND_COMP2)
					close_level();
				else
					bad = 1'b1;
			end
			POS_NOT_CLOSE: begin
				if (c == CH_RPAR)
					close_level();
				else
					bad = 1'b1;
			end
			default: bad = 1'b1;
		endcase
	endfunction

	task note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	// result side first, so a verdict can never match an expectation pushed
	// by a byte taken on the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_parse();
			expected_verdicts.delete();
			fail_count     = 0;
			pending        = 0;
			filters_judged = 0;
			filters_valid  = 0;
			bytes_taken    = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_verdicts.size() == 0) begin
					note_failure($sformatf("verdict %0b arrived with none outstanding",
						valid_res));
				end else begin
					want = expected_verdicts.pop_front();
					filters_judged++;
					if (want)
						filters_valid++;
					if (valid_res !== want)
						note_failure($sformatf("filter %0d: expected valid_res %0b, got %0b",
							filters_judged, want, valid_res));
				end
			end
			if (item_valid && !item_stall) begin
				bytes_taken++;
				if (!bad)
					parse_byte(character);
				if (last) begin
					expected_verdicts.push_back(!bad && pos == POS_DONE);
					restart_parse();
				end
			end
			pending = expected_verdicts.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Feeds filter strings byte by byte into the syntax checker: a directed set
// of corner cases, then random well-formed, damaged and noise strings, with
// random gaps and result back-pressure. The checker module does the scoring.
// ----------------------------------------------------------------------------
module tb_top
	import lfsc_pkg::*;
();

	localparam int LIMIT = 400000;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	logic [7:0] character;
	logic       last;
	logic       result_valid;
	logic       result_stall;
	logic       valid_res;

	int fail_count;
	int pending;
	int filters_judged;
	int filters_valid;
	int bytes_taken;
	int cycle_count;
	int random_bytes;
	int pick;
	bit steady;

	char_t filt [$];
	char_t metas [10] = '{CH_LPAR, CH_RPAR, CH_STAR, CH_BSLASH, CH_BANG,
		CH_AMP, CH_BAR, CH_EQ, CH_LT, CH_GT};

	ldap_filter_syntax_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.character    (character),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.valid_res    (valid_res)
	);

	lfsc_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.character      (character),
		.last           (last),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.valid_res      (valid_res),
		.fail_count     (fail_count),
		.pending        (pending),
		.filters_judged (filters_judged),
		.filters_valid  (filters_valid),
		.bytes_taken    (bytes_taken)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic char_t plain_char(input bit digits);
		char_t c;
		if (digits) begin
			c = CH_ZERO + char_t'($urandom_range(0, 10));
			return (c > CH_NINE) ? CH_MINUS : c;
		end
		do
			c = char_t'($urandom_range(1, 255));
		while (is_special(c));
		return c;
	endfunction

	function automatic void put_segment(input bit digits, input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				filt.push_back(CH_BSLASH);
				filt.push_back(metas[$urandom_range(0, 9)]);
			end else begin
				filt.push_back(plain_char(digits));
			end
		end
	endfunction

	function automatic void gen_leaf();
		int stars;
		put_segment(1'b0, $urandom_range(1, 3));
		case ($urandom_range(0, 2))
			0: begin
				filt.push_back(CH_EQ);
				stars = $urandom_range(0, 3);
				if (stars == 0) begin
					put_segment(1'b0, $urandom_range(1, 3));
				end else begin
					// outer segments may be empty, inner ones may not
					put_segment(1'b0, $urandom_range(0, 2));
					for (int i = 0; i < stars; i++) begin
						filt.push_back(CH_STAR);
						put_segment(1'b0, (i == stars - 1) ? $urandom_range(0, 2) :
							$urandom_range(1, 2));
					end
				end
			end
			1: begin
				filt.push_back(CH_GT);
				put_segment(1'b1, $urandom_range(1, 3));
			end
			default: begin
				filt.push_back(CH_LT);
				put_segment(1'b1, $urandom_range(1, 3));
			end
		endcase
	endfunction

	function automatic void gen_expr(input int lvl);
		int sel;
		int n;
		sel = $urandom_range(0, 9);
		filt.push_back(CH_LPAR);
		if (lvl < 4 && sel < 3) begin
			filt.push_back(sel == 0 ? CH_AMP : CH_BAR);
			n = $urandom_range(2, 3);
			for (int i = 0; i < n; i++)
				gen_expr(lvl + 1);
		end else if (lvl < 4 && sel == 3) begin
			filt.push_back(CH_BANG);
			gen_expr(lvl + 1);
		end else begin
			gen_leaf();
		end
		filt.push_back(CH_RPAR);
	endfunction

	// chain of negations; n + 1 parens open at the leaf
	function automatic void gen_deep(input int n);
		filt.push_back(CH_LPAR);
		for (int i = 0; i < n; i++) begin
			filt.push_back(CH_BANG);
			filt.push_back(CH_LPAR);
		end
		gen_leaf();
		for (int i = 0; i <= n; i++)
			filt.push_back(CH_RPAR);
	endfunction

	function automatic void spoil();
		int at;
		at = $urandom_range(0, filt.size() - 1);
		case ($urandom_range(0, 3))
			0: filt[at] = char_t'($urandom_range(1, 255));
			1: filt[at] = metas[$urandom_range(0, 9)];
			2: begin
				while (filt.size() > at && filt.size() > 1)
					filt.delete(filt.size() - 1);
			end
			default: filt.push_back(char_t'($urandom_range(1, 255)));
		endcase
	endfunction

	function automatic void gen_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			filt.push_back($urandom_range(0, 1) ? metas[$urandom_range(0, 9)] :
				char_t'($urandom_range(1, 255)));
	endfunction

	// entered and left at a falling edge
	task automatic send_byte(input char_t c, input logic fin);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid = 1'b1;
		character  = c;
		last       = fin;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_filter();
		for (int i = 0; i < filt.size(); i++)
			send_byte(filt[i], i == filt.size() - 1);
		filt.delete();
	endtask

	task automatic send_text(input string s);
		filt.delete();
		for (int i = 0; i < s.len(); i++)
			filt.push_back(s[i]);
		send_filter();
	endtask

	// result side: stall for a drawn number of cycles, then take one transaction
	initial begin
		int hold;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = steady ? 0 : $urandom_range(0, 4);
			if (hold > 0) begin
				result_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall = 1'b0;
			@(posedge clk);
			while (result_valid !== 1'b1)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		character   = CH_LPAR;
		last        = 1'b0;
		steady      = 1'b0;
		cycle_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_text("(a=b)");
		send_text("(k\\*=*v*)");
		send_text("(|(a<0)(b>-9)(c=*))");
		send_text("(&(x=1)(!(y=\\))))");
		send_text("(&(a=b))");
		send_text("(a=**)");
		send_text("(a>x)");
		send_text("(a<)");
		send_text("(=b)");
		send_text("(a\\q=b)");
		send_text("((a=b))");
		// trailing byte after the closing paren, then an unfinished string
		send_text("(a=b)x");
		send_text("(a=");
		filt.push_back(8'h01);
		send_filter();
		filt.push_back(8'hFF);
		send_filter();
		// deepest legal nesting, then one level too deep
		gen_deep(MAX_DEPTH_DEF - 1);
		send_filter();
		gen_deep(MAX_DEPTH_DEF);
		send_filter();

		random_bytes = 0;
		while (random_bytes < 200) begin
			steady = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				gen_expr(0);
			end else if (pick == 12) begin
				gen_deep($urandom_range(MAX_DEPTH_DEF - 3, MAX_DEPTH_DEF + 1));
			end else if (pick < 18) begin
				gen_expr(0);
				spoil();
			end else begin
				gen_noise();
			end
			random_bytes += filt.size();
			send_filter();
		end
		item_valid = 1'b0;
		steady     = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d filter strings over %0d bytes: %0d judged valid, %0d rejected",
			filters_judged, bytes_taken, filters_valid, filters_judged - filters_valid);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: ldap_filter_syntax_checker.f
hdl/lfsc_pkg.sv
hdl/ldap_filter_syntax_checker.sv
tb/lfsc_checker.sv
tb/tb_top.sv
